>>> hw/rtl/brfp_pkg.sv
// types and constants shared by the ring fifo with peek
package brfp_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 16;
    localparam int CNT_W  = 7;
    localparam int OFS_W  = 6;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [DATA_W-1:0] DATA_NONE = '1;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_FILL = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } sts_t;

    typedef struct packed {
        act_t                      action;
        logic signed [DATA_W-1:0]  value;
        logic        [OFS_W-1:0]   offset;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        sts_t                      status;
        logic        [CNT_W-1:0]   count;
    } rsp_item_t;

    typedef struct packed {
        logic                from_mem;
        logic                mark;
        logic [DATA_W-1:0]   fill;
        logic [DATA_W-1:0]   const_data;
        sts_t                status;
        logic [CNT_W-1:0]    count;
    } issue_t;

endpackage

>>> hw/rtl/brfp_mem.sv
// entry store, one write port and one registered read port
module brfp_mem
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [brfp_pkg::ADDR_W-1:0]   waddr,
    input  logic [brfp_pkg::DATA_W-1:0]   wdata,
    input  logic                          re,
    input  logic [brfp_pkg::ADDR_W-1:0]   raddr,
    output logic [brfp_pkg::DATA_W-1:0]   rdata
);

    logic [brfp_pkg::DATA_W-1:0] mem [brfp_pkg::DEPTH];
    logic [brfp_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/brfp_ctrl.sv
// head, level, written marks, fill value and capacity; issues memory accesses
module brfp_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  brfp_pkg::req_item_t           req,
    input  logic                          cfg_we,
    input  logic [brfp_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                          mem_we,
    output logic [brfp_pkg::ADDR_W-1:0]   mem_waddr,
    output logic [brfp_pkg::DATA_W-1:0]   mem_wdata,
    output logic                          mem_re,
    output logic [brfp_pkg::ADDR_W-1:0]   mem_raddr,
    output brfp_pkg::issue_t              issue
);

    logic [brfp_pkg::CNT_W-1:0]  capacity_reg, capacity_next;
    logic [brfp_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [brfp_pkg::CNT_W-1:0]  level_reg, level_next;
    logic [brfp_pkg::DEPTH-1:0]  marks_reg, marks_next;
    logic [brfp_pkg::DATA_W-1:0] fill_reg, fill_next;

    logic [brfp_pkg::CNT_W-1:0]  cap;
    logic [brfp_pkg::ADDR_W-1:0] tail;
    logic [brfp_pkg::ADDR_W-1:0] peek_addr;
    logic                        do_write;
    logic                        do_read;
    logic [brfp_pkg::ADDR_W-1:0] raddr;
    brfp_pkg::sts_t              status;
    logic [brfp_pkg::DATA_W-1:0] const_data;

    assign cap       = (capacity_reg > brfp_pkg::DEPTH_CNT) ? brfp_pkg::DEPTH_CNT
                                                             : capacity_reg;
    assign tail      = head_reg + level_reg[brfp_pkg::ADDR_W-1:0];
    assign peek_addr = head_reg + brfp_pkg::ADDR_W'(req.offset);

    always_comb
    begin
        head_next  = head_reg;
        level_next = level_reg;
        marks_next = marks_reg;
        fill_next  = fill_reg;
        do_write   = 1'b0;
        do_read    = 1'b0;
        raddr      = head_reg;
        status     = brfp_pkg::STS_OK;
        const_data = '0;
        case (req.action)
            brfp_pkg::ACT_PUSH:
            begin
                if (level_reg >= cap)
                begin
                    status = brfp_pkg::STS_FULL;
                end
                else
                begin
                    do_write         = 1'b1;
                    marks_next[tail] = 1'b1;
                    level_next       = level_reg + 1'b1;
                end
            end
            brfp_pkg::ACT_POP:
            begin
                if (level_reg == '0)
                begin
                    status     = brfp_pkg::STS_EMPTY;
                    const_data = brfp_pkg::DATA_NONE;
                end
                else
                begin
                    do_read    = 1'b1;
                    head_next  = head_reg + 1'b1;
                    level_next = level_reg - 1'b1;
                end
            end
            brfp_pkg::ACT_PEEK:
            begin
                if (brfp_pkg::CNT_W'(req.offset) >= level_reg)
                begin
                    status     = brfp_pkg::STS_RANGE;
                    const_data = brfp_pkg::DATA_NONE;
                end
                else
                begin
                    do_read = 1'b1;
                    raddr   = peek_addr;
                end
            end
            brfp_pkg::ACT_FILL:
            begin
                marks_next = '0;
                fill_next  = req.value;
                head_next  = '0;
                level_next = cap;
            end
            default:
            begin
                status = brfp_pkg::STS_OK;
            end
        endcase
    end

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_we)
        begin
            capacity_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= brfp_pkg::DEPTH_CNT;
            head_reg     <= '0;
            level_reg    <= '0;
            marks_reg    <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            if (accept)
            begin
                head_reg  <= head_next;
                level_reg <= level_next;
                marks_reg <= marks_next;
                fill_reg  <= fill_next;
            end
        end
    end

    assign mem_we    = accept && do_write;
    assign mem_waddr = tail;
    assign mem_wdata = req.value;
    assign mem_re    = accept && do_read;
    assign mem_raddr = raddr;

    assign issue.from_mem   = do_read;
    assign issue.mark       = marks_reg[raddr];
    assign issue.fill       = fill_reg;
    assign issue.const_data = const_data;
    assign issue.status     = status;
    assign issue.count      = level_next;

endmodule

>>> hw/rtl/brfp_resp.sv
// read-return stage and output register with handshake control
module brfp_resp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    output logic                          accept,
    input  brfp_pkg::issue_t              issue,
    input  logic [brfp_pkg::DATA_W-1:0]   mem_rdata,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output brfp_pkg::rsp_item_t           rsp
);

    logic                 s1_valid_reg, s1_valid_next;
    brfp_pkg::issue_t     s1_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    brfp_pkg::rsp_item_t  rsp_reg, rsp_next;
    logic                 out_free;
    logic                 s1_move;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (s1_move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_next.status = s1_reg.status;
        rsp_next.count  = s1_reg.count;
        if (!s1_reg.from_mem)
        begin
            rsp_next.data = s1_reg.const_data;
        end
        else if (s1_reg.mark)
        begin
            rsp_next.data = mem_rdata;
        end
        else
        begin
            rsp_next.data = s1_reg.fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= issue;
        end
        if (s1_move)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/bounded_ring_fifo_with_peek_top.sv
// top level of the bounded ring fifo with peek
//
//  channel   signals                        direction
//  req       req_valid, req_ready, req      push, pop, peek or fill item in
//  rsp       rsp_valid, rsp_ready, rsp      one result item out per request
//  cfg       cfg_we, cfg_wdata              capacity write, no wait
//
//  a request is decided and its memory access issued in the cycle it is taken;
//  the registered memory read returns in the read stage and moves on into the output register
//  one item per cycle while the output drains; a stalled output holds one item
//  in the read stage and one in the output register before req_ready drops
//  reset clears head, level, marks, fill value and sets capacity to 64
module bounded_ring_fifo_with_peek_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  brfp_pkg::req_item_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output brfp_pkg::rsp_item_t           rsp,
    input  logic                          cfg_we,
    input  logic [brfp_pkg::CNT_W-1:0]    cfg_wdata
);

    logic                          accept;
    logic                          mem_we;
    logic [brfp_pkg::ADDR_W-1:0]   mem_waddr;
    logic [brfp_pkg::DATA_W-1:0]   mem_wdata;
    logic                          mem_re;
    logic [brfp_pkg::ADDR_W-1:0]   mem_raddr;
    logic [brfp_pkg::DATA_W-1:0]   mem_rdata;
    brfp_pkg::issue_t              issue;

    brfp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .issue     (issue)
    );

    brfp_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    brfp_resp u_resp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .accept    (accept),
        .issue     (issue),
        .mem_rdata (mem_rdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
